// ===== sv/sec2cal_pkg.sv =====
// Package: types, constants and microcode for the seconds-to-calendar converter.
`timescale 1ns / 1ps
package sec2cal_pkg;

    localparam int SECS_W  = 32;
    localparam int YEAR_W  = 7;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;

    localparam int MAX_YEARS_DEF = 69;

    localparam logic [SECS_W-1:0] SECS_LEAP_YEAR   = 32'd31622400;
    localparam logic [SECS_W-1:0] SECS_COMMON_YEAR = 32'd31536000;
    localparam logic [SECS_W-1:0] SECS_PER_DAY     = 32'd86400;
    localparam logic [SECS_W-1:0] SECS_PER_HOUR    = 32'd3600;
    localparam logic [SECS_W-1:0] SECS_PER_MIN     = 32'd60;
    localparam logic [SECS_W-1:0] SECS_FEB_COMMON  = 32'd2419200;

    localparam int NUM_MONTHS = 12;
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_LAST = 4'd11;

    // Month lengths in seconds, February as in a leap year.
    localparam logic [SECS_W-1:0] MONTH_SECS [NUM_MONTHS] = '{
        32'd2678400, 32'd2505600, 32'd2678400, 32'd2592000,
        32'd2678400, 32'd2592000, 32'd2678400, 32'd2678400,
        32'd2592000, 32'd2678400, 32'd2592000, 32'd2678400
    };

    // Saturated result when the count runs past the last year.
    localparam logic [MONTH_W-1:0] SAT_MONTH = 4'd12;
    localparam logic [DAY_W-1:0]   SAT_DAY   = 5'd31;
    localparam logic [HOUR_W-1:0]  SAT_HOUR  = 5'd23;
    localparam logic [MIN_W-1:0]   SAT_MIN   = 6'd59;
    localparam logic [SEC_W-1:0]   SAT_SEC   = 6'd59;

    typedef enum logic [2:0] {
        K_NONE  = 3'd0,
        K_YEAR  = 3'd1,
        K_MONTH = 3'd2,
        K_DAY   = 3'd3,
        K_HOUR  = 3'd4,
        K_MIN   = 3'd5
    } t_ksel;

    localparam int UC_DEPTH = 6;
    localparam int UPC_W    = $clog2(UC_DEPTH);
    typedef logic [UPC_W-1:0] t_upc;

    localparam t_upc A_YEAR  = 3'd0;
    localparam t_upc A_MONTH = 3'd1;
    localparam t_upc A_DAY   = 3'd2;
    localparam t_upc A_HOUR  = 3'd3;
    localparam t_upc A_MIN   = 3'd4;
    localparam t_upc A_DONE  = 3'd5;

    typedef struct packed {
        t_ksel ksel;
        logic  loop;
        logic  fin;
        t_upc  nxt;
    } t_uop;

    localparam t_uop UCODE [UC_DEPTH] = '{
        '{ksel: K_YEAR,  loop: 1'b1, fin: 1'b0, nxt: A_MONTH},
        '{ksel: K_MONTH, loop: 1'b1, fin: 1'b0, nxt: A_DAY},
        '{ksel: K_DAY,   loop: 1'b1, fin: 1'b0, nxt: A_HOUR},
        '{ksel: K_HOUR,  loop: 1'b1, fin: 1'b0, nxt: A_MIN},
        '{ksel: K_MIN,   loop: 1'b1, fin: 1'b0, nxt: A_DONE},
        '{ksel: K_NONE,  loop: 1'b0, fin: 1'b1, nxt: A_YEAR}
    };

    typedef struct packed {
        logic  load;
        logic  step;
        logic  sat;
        logic  finish;
        t_ksel ksel;
    } t_dp_ctl;

    typedef struct packed {
        logic ge;
        logic max_year;
        logic last_month;
    } t_dp_sts;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
    } t_result;

endpackage

// ===== sv/seconds_to_calendar_date_time.sv =====
// Top level: seconds-since-2000 to calendar date and time converter.
`timescale 1ns / 1ps
// Converts a signed seconds count since 2000-01-01 00:00:00 (sign dropped) to
// year offset, month, day, hour, minute and second. Pulse start while busy is
// low to issue a request; busy stays high until the result is out. The result
// appears on the o_ ports for exactly one cycle with o_valid high and must be
// captured then: there is no backpressure. A small microcode program drives a
// single 32-bit compare-subtract unit, at most one subtraction per cycle,
// removing whole years, months, days, hours and minutes in turn. A count past
// the end of year offset MAX_YEARS stops early and returns the last second of
// that year.
module seconds_to_calendar_date_time #(
    parameter int MAX_YEARS = sec2cal_pkg::MAX_YEARS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [sec2cal_pkg::SECS_W-1:0] i_seconds_count,
    output logic                                  o_valid,
    output logic [sec2cal_pkg::YEAR_W-1:0]        o_year_offset,
    output logic [sec2cal_pkg::MONTH_W-1:0]       o_month_number,
    output logic [sec2cal_pkg::DAY_W-1:0]         o_day_of_month,
    output logic [sec2cal_pkg::HOUR_W-1:0]        o_hour_of_day,
    output logic [sec2cal_pkg::MIN_W-1:0]         o_minute_of_hour,
    output logic [sec2cal_pkg::SEC_W-1:0]         o_second_of_minute
);
    import sec2cal_pkg::*;

    t_dp_ctl ctl;
    t_dp_sts sts;
    t_result res;
    logic    r_valid;

    sec2cal_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_busy  (busy)
    );

    sec2cal_dp #(
        .MAX_YEARS (MAX_YEARS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_seconds (i_seconds_count),
        .i_ctl     (ctl),
        .o_sts     (sts),
        .o_result  (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= ctl.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.finish) begin
            o_year_offset      <= res.year;
            o_month_number     <= res.month;
            o_day_of_month     <= res.day;
            o_hour_of_day      <= res.hour;
            o_minute_of_hour   <= res.minute;
            o_second_of_minute <= res.second;
        end
    end

    assign o_valid = r_valid;

endmodule

// ===== sv/sec2cal_dp.sv =====
// Datapath: remainder register, constant select, compare-subtract and field counters.
`timescale 1ns / 1ps
module sec2cal_dp #(
    parameter int MAX_YEARS = sec2cal_pkg::MAX_YEARS_DEF
) (
    input  logic                                i_clk,
    input  logic [sec2cal_pkg::SECS_W-1:0]      i_seconds,
    input  sec2cal_pkg::t_dp_ctl                i_ctl,
    output sec2cal_pkg::t_dp_sts                o_sts,
    output sec2cal_pkg::t_result                o_result
);
    import sec2cal_pkg::*;

    logic [SECS_W-1:0]  r_rem;
    logic [YEAR_W-1:0]  r_year;
    logic [MONTH_W-1:0] r_month;
    logic [DAY_W-1:0]   r_day;
    logic [HOUR_W-1:0]  r_hour;
    logic [MIN_W-1:0]   r_min;
    logic               r_sat;

    logic [SECS_W-1:0]  k;
    logic [SECS_W:0]    diff;
    logic [SECS_W-1:0]  mag;
    logic               leap;

    assign leap = (r_year[1:0] == 2'b00);
    assign mag  = i_seconds[SECS_W-1] ? (~i_seconds + 1'b1) : i_seconds;

    always_comb begin
        unique case (i_ctl.ksel)
            K_YEAR:  k = leap ? SECS_LEAP_YEAR : SECS_COMMON_YEAR;
            K_MONTH: k = (r_month == MONTH_FEB && !leap) ? SECS_FEB_COMMON
                                                         : MONTH_SECS[r_month];
            K_DAY:   k = SECS_PER_DAY;
            K_HOUR:  k = SECS_PER_HOUR;
            K_MIN:   k = SECS_PER_MIN;
            default: k = '0;
        endcase
    end

    assign diff = {1'b0, r_rem} - {1'b0, k};

    assign o_sts.ge         = !diff[SECS_W];
    assign o_sts.max_year   = (r_year == YEAR_W'(MAX_YEARS));
    assign o_sts.last_month = (r_month == MONTH_LAST);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_rem   <= mag;
            r_year  <= '0;
            r_month <= '0;
            r_day   <= '0;
            r_hour  <= '0;
            r_min   <= '0;
            r_sat   <= 1'b0;
        end else begin
            if (i_ctl.sat) begin
                r_sat <= 1'b1;
            end
            if (i_ctl.step) begin
                r_rem <= diff[SECS_W-1:0];
                unique case (i_ctl.ksel)
                    K_YEAR:  r_year  <= r_year + 1'b1;
                    K_MONTH: r_month <= r_month + 1'b1;
                    K_DAY:   r_day   <= r_day + 1'b1;
                    K_HOUR:  r_hour  <= r_hour + 1'b1;
                    K_MIN:   r_min   <= r_min + 1'b1;
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        if (r_sat) begin
            o_result.year   = YEAR_W'(MAX_YEARS);
            o_result.month  = SAT_MONTH;
            o_result.day    = SAT_DAY;
            o_result.hour   = SAT_HOUR;
            o_result.minute = SAT_MIN;
            o_result.second = SAT_SEC;
        end else begin
            o_result.year   = r_year;
            o_result.month  = r_month + 1'b1;
            o_result.day    = r_day + 1'b1;
            o_result.hour   = r_hour;
            o_result.minute = r_min;
            o_result.second = r_rem[SEC_W-1:0];
        end
    end

endmodule

// ===== sv/sec2cal_seq.sv =====
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
`timescale 1ns / 1ps
module sec2cal_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  sec2cal_pkg::t_dp_sts i_sts,
    output sec2cal_pkg::t_dp_ctl o_ctl,
    output logic                 o_busy
);
    import sec2cal_pkg::*;

    t_upc r_pc, n_pc;
    logic r_busy, n_busy;
    t_uop uop;
    logic take;
    logic sat_hit;

    assign uop     = UCODE[r_pc];
    assign take    = i_sts.ge && !(uop.ksel == K_MONTH && i_sts.last_month);
    assign sat_hit = (uop.ksel == K_YEAR) && take && i_sts.max_year;

    always_comb begin
        o_ctl.load   = i_start && !r_busy;
        o_ctl.finish = r_busy && uop.fin;
        o_ctl.sat    = r_busy && !uop.fin && sat_hit;
        o_ctl.step   = r_busy && !uop.fin && uop.loop && take && !sat_hit;
        o_ctl.ksel   = uop.ksel;
    end

    always_comb begin
        n_pc   = r_pc;
        n_busy = r_busy;
        if (o_ctl.load) begin
            n_pc   = A_YEAR;
            n_busy = 1'b1;
        end else if (r_busy) begin
            priority if (uop.fin) begin
                n_pc   = uop.nxt;
                n_busy = 1'b0;
            end else if (sat_hit) begin
                n_pc = A_DONE;
            end else if (take && uop.loop) begin
                n_pc = r_pc;
            end else begin
                n_pc = uop.nxt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= A_YEAR;
            r_busy <= 1'b0;
        end else begin
            r_pc   <= n_pc;
            r_busy <= n_busy;
        end
    end

    assign o_busy = r_busy;

endmodule

// ===== sv/sec2cal_chk.sv =====
// Port-level checker for the seconds-to-calendar converter, with its bind.
`timescale 1ns / 1ps
module sec2cal_chk (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  start,
    input logic                                  busy,
    input logic signed [sec2cal_pkg::SECS_W-1:0] i_seconds_count,
    input logic                                  o_valid,
    input logic [sec2cal_pkg::YEAR_W-1:0]        o_year_offset,
    input logic [sec2cal_pkg::MONTH_W-1:0]       o_month_number,
    input logic [sec2cal_pkg::DAY_W-1:0]         o_day_of_month,
    input logic [sec2cal_pkg::HOUR_W-1:0]        o_hour_of_day,
    input logic [sec2cal_pkg::MIN_W-1:0]         o_minute_of_hour,
    input logic [sec2cal_pkg::SEC_W-1:0]         o_second_of_minute
);

    a_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but busy not raised");

    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_done_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> o_valid)
        else $error("busy dropped without a result");

    a_fields_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_month_number >= 4'd1 && o_month_number <= 4'd12 &&
                     o_day_of_month >= 5'd1 && o_hour_of_day <= 5'd23 &&
                     o_minute_of_hour <= 6'd59 && o_second_of_minute <= 6'd59 &&
                     o_year_offset <= 7'd99))
        else $error("result field out of range");

endmodule

bind seconds_to_calendar_date_time sec2cal_chk u_sec2cal_chk (.*);

// ===== test/seconds_to_calendar_checker.sv =====
// Checker: predicts each conversion from the accepted request and compares the strobed result.
`timescale 1ns / 1ps
module seconds_to_calendar_checker #(
    parameter int MAX_YEARS = sec2cal_pkg::MAX_YEARS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic                                  i_busy,
    input  logic signed [sec2cal_pkg::SECS_W-1:0] i_seconds_count,
    input  logic                                  i_valid,
    input  logic [sec2cal_pkg::YEAR_W-1:0]        i_year_offset,
    input  logic [sec2cal_pkg::MONTH_W-1:0]       i_month_number,
    input  logic [sec2cal_pkg::DAY_W-1:0]         i_day_of_month,
    input  logic [sec2cal_pkg::HOUR_W-1:0]        i_hour_of_day,
    input  logic [sec2cal_pkg::MIN_W-1:0]         i_minute_of_hour,
    input  logic [sec2cal_pkg::SEC_W-1:0]         i_second_of_minute,
    output int                                    o_fail_count,
    output int                                    o_pending,
    output int                                    o_checked
);
    import sec2cal_pkg::*;

    localparam int unsigned DAYS_IN_MONTH [NUM_MONTHS] = '{
        31, 29, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31
    };

    t_result dates_due [$];
    int      fail_count = 0;
    int      checked = 0;
    int      pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;
    assign o_checked    = checked;

    function automatic t_result calendar_of(logic [SECS_W-1:0] raw);
        logic [SECS_W-1:0] rem;
        logic [SECS_W-1:0] year_len;
        int unsigned       yr;
        int unsigned       mon;
        int unsigned       mlen;
        int unsigned       days_begin;
        int unsigned       days_end;
        logic              found;
        t_result           r;
        rem = raw[SECS_W-1] ? (~raw + 1'b1) : raw;
        found = 1'b0;
        for (yr = 0; yr <= MAX_YEARS; yr++) begin
            year_len = (yr % 4 == 0) ? SECS_LEAP_YEAR : SECS_COMMON_YEAR;
            if (rem < year_len) begin
                found = 1'b1;
                break;
            end
            rem -= year_len;
        end
        if (!found) begin
            r.year   = YEAR_W'(MAX_YEARS);
            r.month  = SAT_MONTH;
            r.day    = SAT_DAY;
            r.hour   = SAT_HOUR;
            r.minute = SAT_MIN;
            r.second = SAT_SEC;
            return r;
        end
        days_begin = 0;
        days_end = 0;
        for (mon = 0; mon < NUM_MONTHS; mon++) begin
            days_begin = days_end;
            mlen = DAYS_IN_MONTH[mon];
            if (mon == MONTH_FEB && yr % 4 != 0) mlen = mlen - 1;
            days_end += mlen;
            if (rem < days_end * SECS_PER_DAY) break;
        end
        if (mon > MONTH_LAST) mon = MONTH_LAST;
        rem -= days_begin * SECS_PER_DAY;
        r.year   = YEAR_W'(yr);
        r.month  = MONTH_W'(mon + 1);
        r.day    = DAY_W'(rem / SECS_PER_DAY + 1);
        rem      = rem % SECS_PER_DAY;
        r.hour   = HOUR_W'(rem / SECS_PER_HOUR);
        rem      = rem % SECS_PER_HOUR;
        r.minute = MIN_W'(rem / SECS_PER_MIN);
        r.second = SEC_W'(rem % SECS_PER_MIN);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (i_start && !i_busy) dates_due.push_back(calendar_of(i_seconds_count));
            if (i_valid) begin
                if (dates_due.size() == 0) begin
                    $error("result with no request pending");
                    fail_count++;
                end else begin
                    want = dates_due.pop_front();
                    checked++;
                    if (i_year_offset !== want.year) begin
                        $error("year_offset: expected %0d, got %0d", want.year, i_year_offset);
                        fail_count++;
                    end
                    if (i_month_number !== want.month) begin
                        $error("month_number: expected %0d, got %0d", want.month,
                               i_month_number);
                        fail_count++;
                    end
                    if (i_day_of_month !== want.day) begin
                        $error("day_of_month: expected %0d, got %0d", want.day, i_day_of_month);
                        fail_count++;
                    end
                    if (i_hour_of_day !== want.hour) begin
                        $error("hour_of_day: expected %0d, got %0d", want.hour, i_hour_of_day);
                        fail_count++;
                    end
                    if (i_minute_of_hour !== want.minute) begin
                        $error("minute_of_hour: expected %0d, got %0d", want.minute,
                               i_minute_of_hour);
                        fail_count++;
                    end
                    if (i_second_of_minute !== want.second) begin
                        $error("second_of_minute: expected %0d, got %0d", want.second,
                               i_second_of_minute);
                        fail_count++;
                    end
                end
            end
            pending_count = dates_due.size();
        end
    end

endmodule

// ===== test/seconds_to_calendar_date_time_test.sv =====
// Testbench top: drives conversion requests into the converter and reports the verdict.
`timescale 1ns / 1ps
module seconds_to_calendar_date_time_test;
    import sec2cal_pkg::*;

    localparam int DUT_MAX_YEARS = MAX_YEARS_DEF;
    localparam int RANDOM_ITEMS  = 2000;
    localparam int CALM_TAIL     = 300;
    localparam int STALL_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 250;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic signed [SECS_W-1:0] seconds_count = '0;
    logic                     o_valid;
    logic [YEAR_W-1:0]        o_year_offset;
    logic [MONTH_W-1:0]       o_month_number;
    logic [DAY_W-1:0]         o_day_of_month;
    logic [HOUR_W-1:0]        o_hour_of_day;
    logic [MIN_W-1:0]         o_minute_of_hour;
    logic [SEC_W-1:0]         o_second_of_minute;
    int                       fail_count;
    int                       pending;
    int                       checked;
    int                       sent = 0;
    int                       directed_sent = 0;
    int                       quiet_cycles = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    seconds_to_calendar_date_time #(.MAX_YEARS(DUT_MAX_YEARS)) DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_seconds_count    (seconds_count),
        .o_valid            (o_valid),
        .o_year_offset      (o_year_offset),
        .o_month_number     (o_month_number),
        .o_day_of_month     (o_day_of_month),
        .o_hour_of_day      (o_hour_of_day),
        .o_minute_of_hour   (o_minute_of_hour),
        .o_second_of_minute (o_second_of_minute)
    );

    seconds_to_calendar_checker #(.MAX_YEARS(DUT_MAX_YEARS)) u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (start),
        .i_busy             (busy),
        .i_seconds_count    (seconds_count),
        .i_valid            (o_valid),
        .i_year_offset      (o_year_offset),
        .i_month_number     (o_month_number),
        .i_day_of_month     (o_day_of_month),
        .i_hour_of_day      (o_hour_of_day),
        .i_minute_of_hour   (o_minute_of_hour),
        .i_second_of_minute (o_second_of_minute),
        .o_fail_count       (fail_count),
        .o_pending          (pending),
        .o_checked          (checked)
    );

    // watchdog: no request or result accepted for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_request(logic [SECS_W-1:0] value);
        seconds_count <= value;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        sent++;
    endtask

    task automatic hold_off(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    function automatic logic [SECS_W-1:0] year_start(int unsigned yr);
        logic [SECS_W-1:0] acc;
        acc = '0;
        for (int unsigned y = 0; y < yr; y++)
            acc += (y % 4 == 0) ? SECS_LEAP_YEAR : SECS_COMMON_YEAR;
        return acc;
    endfunction

    function automatic logic [SECS_W-1:0] month_start(int unsigned yr, int unsigned mon);
        logic [SECS_W-1:0] acc;
        acc = year_start(yr);
        for (int unsigned m = 0; m < mon; m++) begin
            acc += MONTH_SECS[m];
            if (m == MONTH_FEB && yr % 4 != 0) acc -= SECS_PER_DAY;
        end
        return acc;
    endfunction

    // mostly well-formed dates and calendar edges, some raw patterns
    function automatic logic [SECS_W-1:0] random_count();
        logic [SECS_W-1:0] v;
        int unsigned       yr;
        yr = $urandom_range(0, 68);
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1, 2: v = year_start(yr) + $urandom_range(0, 365) * SECS_PER_DAY
                      + $urandom_range(0, SECS_PER_DAY - 1);
            3: v = month_start(yr, $urandom_range(0, NUM_MONTHS - 1))
                   + $urandom_range(0, 4) - 2;
            4: v = year_start(yr) + $urandom_range(0, 4) - 2;
            default: v = $urandom_range(0, 3 * SECS_PER_DAY);
        endcase
        if ($urandom_range(0, 3) == 0) v = ~v + 1'b1;
        return v;
    endfunction

    logic [SECS_W-1:0] directed [] = '{
        32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
        32'd2678399, 32'd2678400,
        32'd5097599, 32'd5097600,
        32'd31622399, 32'd31622400,
        32'd36719999, 32'd36720000,
        32'd63158399, 32'd126230400,
        32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000, 32'hFFFF_FFFF,
        32'h5555_5555, 32'h2AAA_AAAA, 32'hAAAA_AAAA
    };

    initial begin
        bit idle_phase;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) send_request(directed[k]);
        directed_sent = sent;

        // let every directed request come back before random traffic
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);

        idle_phase = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 150 == 0) idle_phase = ($urandom_range(0, 2) != 0);
            if (idle_phase && n < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 2) == 0)
                hold_off($urandom_range(1, 11));
            send_request(random_count());
        end
        start <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("converted %0d counts: %0d directed edges (month, leap day, year, sign extremes)",
                 checked, directed_sent);
        $display("and %0d random dates, calendar boundaries and raw 32-bit patterns",
                 sent - directed_sent);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
